@@ rtl/xrr_pkg.sv @@
`default_nettype none
package xrr_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CHANCE_W = 31;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CNT_W    = $clog2(WORD_W);

  localparam logic [WORD_W-1:0] SEED_WORD = 32'd12345;

  localparam logic [KIND_W-1:0] KIND_RAW    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BIT    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHANCE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RANGE  = 2'd3;

  typedef struct packed {
    logic load_req;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic req_error;
    logic need_div;
    logic div_last;
  } status_t;

  function automatic logic [WORD_W-1:0] next_word(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    a = w ^ (w << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage
`default_nettype wire

@@ rtl/xrr_req_if.sv @@
`default_nettype none
interface xrr_req_if;
  logic                              valid;
  logic                              ready;
  logic [xrr_pkg::KIND_W-1:0]        kind;
  logic [xrr_pkg::CHANCE_W-1:0]      chance;
  logic signed [xrr_pkg::WORD_W-1:0] range_low;
  logic signed [xrr_pkg::WORD_W-1:0] range_high;

  modport source (output valid, kind, chance, range_low, range_high, input ready);
  modport sink (input valid, kind, chance, range_low, range_high, output ready);
endinterface
`default_nettype wire

@@ rtl/xrr_rsp_if.sv @@
`default_nettype none
interface xrr_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [xrr_pkg::WORD_W-1:0]        raw_word;
  logic                              flag_bit;
  logic signed [xrr_pkg::WORD_W-1:0] ranged_value;
  logic                              error;

  modport source (output valid, raw_word, flag_bit, ranged_value, error, input ready);
  modport sink (input valid, raw_word, flag_bit, ranged_value, error, output ready);
endinterface
`default_nettype wire

@@ rtl/xrr_datapath.sv @@
`default_nettype none
module xrr_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire xrr_pkg::cmd_t                     cmd,
  output xrr_pkg::status_t                       status,
  input  wire logic [xrr_pkg::KIND_W-1:0]        kind,
  input  wire logic [xrr_pkg::CHANCE_W-1:0]      chance,
  input  wire logic signed [xrr_pkg::WORD_W-1:0] range_low,
  input  wire logic signed [xrr_pkg::WORD_W-1:0] range_high,
  output logic [xrr_pkg::WORD_W-1:0]             raw_word,
  output logic                                   flag_bit,
  output logic signed [xrr_pkg::WORD_W-1:0]      ranged_value,
  output logic                                   error
);

  logic [xrr_pkg::WORD_W-1:0]   gen_word;
  logic [xrr_pkg::KIND_W-1:0]   kind_r;
  logic                         err_r;
  logic [xrr_pkg::WORD_W-1:0]   low_r;
  logic [xrr_pkg::WORD_W:0]     divisor;
  logic [xrr_pkg::WORD_W-1:0]   dividend;
  logic [xrr_pkg::WORD_W-1:0]   rem;
  logic [xrr_pkg::CNT_W-1:0]    count;

  logic [xrr_pkg::WORD_W-1:0]   word_next;
  logic [xrr_pkg::WORD_W:0]     span;
  logic                         req_error;
  logic [xrr_pkg::WORD_W:0]     shifted;
  logic [xrr_pkg::WORD_W+1:0]   trial;
  logic                         flag_next;
  logic [xrr_pkg::WORD_W-1:0]   ranged_next;

  always_comb begin
    word_next = xrr_pkg::next_word(gen_word);
    span      = {1'b0, range_high - range_low} + {{xrr_pkg::WORD_W{1'b0}}, 1'b1};
    req_error = ((kind == xrr_pkg::KIND_CHANCE) && (chance == '0)) ||
                ((kind == xrr_pkg::KIND_RANGE) && (range_high < range_low));
    shifted   = {rem, dividend[xrr_pkg::WORD_W-1]};
    trial     = {1'b0, shifted} - {1'b0, divisor};
  end

  always_comb begin
    flag_next   = 1'b0;
    ranged_next = '0;
    if (!err_r) begin
      case (kind_r)
        xrr_pkg::KIND_BIT:    flag_next = gen_word[0];
        xrr_pkg::KIND_CHANCE: flag_next = (rem == '0);
        xrr_pkg::KIND_RANGE:  ranged_next = low_r + rem;
        default:              flag_next = 1'b0;
      endcase
    end
  end

  assign status.req_error = req_error;
  assign status.need_div  = (kind == xrr_pkg::KIND_CHANCE) || (kind == xrr_pkg::KIND_RANGE);
  assign status.div_last  = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_word <= xrr_pkg::SEED_WORD;
    end else if (cmd.load_req && !req_error) begin
      gen_word <= word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      kind_r   <= kind;
      err_r    <= req_error;
      low_r    <= range_low;
      dividend <= word_next;
      rem      <= '0;
      count    <= xrr_pkg::CNT_W'(xrr_pkg::WORD_W - 1);
      if (kind == xrr_pkg::KIND_CHANCE) begin
        divisor <= {{(xrr_pkg::WORD_W + 1 - xrr_pkg::CHANCE_W){1'b0}}, chance};
      end else begin
        divisor <= span;
      end
    end else if (cmd.div_step) begin
      dividend <= {dividend[xrr_pkg::WORD_W-2:0], 1'b0};
      count    <= count - 1'b1;
      if (!trial[xrr_pkg::WORD_W+1]) begin
        rem <= trial[xrr_pkg::WORD_W-1:0];
      end else begin
        rem <= shifted[xrr_pkg::WORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      error        <= err_r;
      raw_word     <= err_r ? '0 : gen_word;
      flag_bit     <= flag_next;
      ranged_value <= ranged_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/xrr_ctrl.sv @@
`default_nettype none
module xrr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_ready,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output xrr_pkg::cmd_t         cmd,
  input  wire xrr_pkg::status_t status
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd.load_req = 1'b0;
    cmd.div_step = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          if (status.req_error || !status.need_div) begin
            state_next = S_LOAD;
          end else begin
            state_next = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_req, cmd.div_step, cmd.load_out}))
    else $error("more than one datapath command at once");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!rsp_valid || rsp_ready))
    else $error("result overwritten before it was taken");

  a_error_skips_div: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_req && status.req_error) |=> (state == S_LOAD))
    else $error("refused request entered the divider");

  a_load_fills: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> rsp_valid)
    else $error("result load did not raise valid");

endmodule
`default_nettype wire

@@ rtl/xorshift_random_ranged.sv @@
// 32-bit xorshift generator (13, 17, 5) seeded with 12345 at reset. Each request advances the
// word once and returns it as a raw word, its low bit, a one-in-chance test or a value in an
// inclusive signed range. Raw and bit requests go from accept straight to result load; chance
// and range requests pass accept, 32 steps of a radix-2 restoring remainder unit, then load.
// A zero chance or reversed bounds return error with all other fields zero and keep the state;
// they skip the divider. One request is in work at a time; a finished result waits in the output
// register while the next request is taken.
`default_nettype none
module xorshift_random_ranged (
  input  wire logic clk,
  input  wire logic rst,
  xrr_req_if.sink   req,
  xrr_rsp_if.source rsp
);

  xrr_pkg::cmd_t    cmd;
  xrr_pkg::status_t status;

  xrr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .status    (status)
  );

  xrr_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .kind         (req.kind),
    .chance       (req.chance),
    .range_low    (req.range_low),
    .range_high   (req.range_high),
    .raw_word     (rsp.raw_word),
    .flag_bit     (rsp.flag_bit),
    .ranged_value (rsp.ranged_value),
    .error        (rsp.error)
  );

endmodule
`default_nettype wire
